// ----- rtl/core/assert_macros.svh -----
// Assertion helpers used by the tte_props checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Holds at every clock edge outside reset.
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ----- rtl/core/tte_pkg.sv -----
package tte_pkg;

  localparam int IN_TDATA_W  = 144;
  localparam int OUT_TDATA_W = 72;
  localparam int OUT_TUSER_W = 2;
  localparam int GEN_W       = 8;

  localparam logic KIND_PROBE = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  localparam logic [1:0] BND_UPPER = 2'd0;
  localparam logic [1:0] BND_LOWER = 2'd1;
  localparam logic [1:0] BND_EXACT = 2'd2;

  // One table entry as it sits in memory.
  typedef struct packed {
    logic [63:0] key;
    logic [7:0]  gen;
    logic [1:0]  bound;
    logic [7:0]  depth;
    logic [15:0] eval;
    logic [15:0] score;
    logic [23:0] move;
  } tte_entry_t;

  // Saturates an 18-bit signed value to the 16-bit signed range.
  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/transposition_table_engine.sv -----
// Flow: the slot is read as an input transaction is taken; the result is registered once
// the lookup state finds the output free, and the write-back is made then. Only one
// probe or store is in flight, as s_tready is low in the lookup state and a stall holds it.
// Reset: synchronous; afterwards a sweep zeroes every table entry while s_tready stays
// low. Generation writes are taken at any time.
module transposition_table_engine #(
  parameter int TABLE_ENTRIES  = 4096,
  parameter int PLY_LIMIT      = 128,
  parameter int MATE_VALUE     = 32000,
  parameter int INFINITE_VALUE = 32001
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              gen_we,
  input  logic [tte_pkg::GEN_W-1:0]         gen_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // tdata from bit 0: key, move_code, score_in, eval_in, depth_in, bound_in, ply, zero pad
  input  logic [tte_pkg::IN_TDATA_W-1:0]    s_tdata,
  // tuser: kind
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // tdata from bit 0: move_out, score_out, eval_out, depth_out, bound_out, zero pad
  output logic [tte_pkg::OUT_TDATA_W-1:0]   m_tdata,
  // tuser from bit 0: hit, stored
  output logic [tte_pkg::OUT_TUSER_W-1:0]   m_tuser
);
  import tte_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam logic signed [17:0] MATE_T  = 18'(MATE_VALUE - PLY_LIMIT);
  localparam logic signed [15:0] INF_POS = 16'(INFINITE_VALUE);
  localparam logic signed [15:0] INF_NEG = 16'(-INFINITE_VALUE);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  tte_entry_t mem [TABLE_ENTRIES];
  tte_entry_t rd_entry;
  tte_entry_t mem_wd;
  logic [IDX_W-1:0] mem_wa;
  logic [IDX_W-1:0] rd_addr;
  logic             mem_we;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [IDX_W-1:0] clr_addr;
  logic [GEN_W-1:0] cur_gen;

  logic               it_kind;
  logic [63:0]        it_key;
  logic [23:0]        it_move;
  logic signed [15:0] it_score;
  logic signed [15:0] it_eval;
  logic signed [8:0]  it_depth;
  logic [1:0]         it_bound;
  logic [7:0]         it_ply;

  logic               in_fire;
  logic               out_free;
  logic               done;
  logic               hit;
  logic               replace;
  logic signed [17:0] old_sc;
  logic signed [17:0] new_sc;
  logic signed [17:0] ply_ext;
  logic signed [17:0] probe_sc;
  logic signed [17:0] store_sc;
  logic signed [15:0] eval_clamped;
  logic signed [7:0]  depth_clamped;
  logic signed [8:0]  old_depth;

  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign done     = (state == ST_LOOKUP) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_gen <= '0;
    end else if (gen_we) begin
      cur_gen <= gen_data;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_addr == {IDX_W{1'b1}}) state_next = ST_IDLE;
      ST_IDLE:   if (in_fire) state_next = ST_LOOKUP;
      ST_LOOKUP: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_kind  <= s_tuser;
      it_key   <= s_tdata[63:0];
      it_move  <= s_tdata[87:64];
      it_score <= s_tdata[103:88];
      it_eval  <= s_tdata[119:104];
      it_depth <= s_tdata[128:120];
      it_bound <= s_tdata[130:129];
      it_ply   <= s_tdata[138:131];
    end
  end

  // While idle the port reads the slot of whatever is offered; after acceptance it keeps
  // reading the held slot, which stays unchanged until the write-back.
  assign rd_addr = (state == ST_IDLE) ? s_tdata[IDX_W-1:0] : it_key[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_entry <= mem[rd_addr];
  end

  always_comb begin
    hit     = (rd_entry.key == it_key);
    ply_ext = $signed({10'b0, it_ply});
    old_sc  = {{2{rd_entry.score[15]}}, rd_entry.score};
    new_sc  = {{2{it_score[15]}}, it_score};

    // Mate scores are stored relative to the root and returned relative to this ply.
    if (old_sc > MATE_T) begin
      probe_sc = old_sc - ply_ext;
    end else if (old_sc < -MATE_T) begin
      probe_sc = old_sc + ply_ext;
    end else begin
      probe_sc = old_sc;
    end

    if (new_sc > MATE_T) begin
      store_sc = new_sc + ply_ext;
    end else if (new_sc < -MATE_T) begin
      store_sc = new_sc - ply_ext;
    end else begin
      store_sc = new_sc;
    end

    if (it_eval > INF_POS) begin
      eval_clamped = INF_POS;
    end else if (it_eval < INF_NEG) begin
      eval_clamped = INF_NEG;
    end else begin
      eval_clamped = it_eval;
    end

    if (it_depth < -9'sd1) begin
      depth_clamped = -8'sd1;
    end else if (it_depth > 9'sd127) begin
      depth_clamped = 8'sd127;
    end else begin
      depth_clamped = it_depth[7:0];
    end

    // The replacement rule looks at the unclamped depth.
    old_depth = {rd_entry.depth[7], rd_entry.depth};
    replace   = !hit || (it_bound == BND_EXACT) || (it_depth >= old_depth) ||
                (rd_entry.gen != cur_gen);
  end

  always_comb begin
    if (state == ST_CLEAR) begin
      mem_we = 1'b1;
      mem_wa = clr_addr;
      mem_wd = '0;
    end else begin
      mem_we       = done && (it_kind == KIND_STORE) && replace;
      mem_wa       = it_key[IDX_W-1:0];
      mem_wd.key   = it_key;
      mem_wd.gen   = cur_gen;
      mem_wd.bound = it_bound;
      mem_wd.depth = depth_clamped;
      mem_wd.eval  = eval_clamped;
      mem_wd.score = sat16(store_sc);
      mem_wd.move  = it_move;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (done) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      if (it_kind == KIND_PROBE && hit) begin
        m_tuser <= 2'b01;
        m_tdata <= {6'b0, rd_entry.bound, rd_entry.depth, rd_entry.eval,
                    sat16(probe_sc), rd_entry.move};
      end else begin
        m_tuser <= {(it_kind == KIND_STORE) && replace, 1'b0};
        m_tdata <= '0;
      end
    end
  end

endmodule

// ----- rtl/core/tte_checker.sv -----
`include "assert_macros.svh"

module tte_props (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [tte_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input logic [tte_pkg::OUT_TUSER_W-1:0]   m_tuser
);
  import tte_pkg::*;

  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped while stalled")
  `CHK_ALWAYS(a_hit_xor_stored, !(m_tvalid && m_tuser[0] && m_tuser[1]), "hit and stored both set")
  `CHK_SAME(a_miss_zero, m_tvalid && !m_tuser[0], m_tdata == '0, "data on a miss or store result")
  `CHK_SAME(a_depth_range, m_tvalid, !m_tdata[63] || m_tdata[63:56] == 8'hFF, "depth out of range")
  `CHK_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "second item taken during lookup")

endmodule

bind transposition_table_engine tte_props u_tte_checker (.*);

// ----- bench/tte_checker.sv -----
`timescale 1ns / 1ps

module tte_checker #(
  parameter int TABLE_ENTRIES  = 4096,
  parameter int PLY_LIMIT      = 128,
  parameter int MATE_VALUE     = 32000,
  parameter int INFINITE_VALUE = 32001
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            gen_we,
  input  logic [tte_pkg::GEN_W-1:0]       gen_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tte_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tuser,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [tte_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic [tte_pkg::OUT_TUSER_W-1:0] m_tuser,
  output int                              fail_count,
  output int                              pending
);
  import tte_pkg::*;

  localparam int SLOT_W     = $clog2(TABLE_ENTRIES);
  localparam int MATE_BOUND = MATE_VALUE - PLY_LIMIT;

  typedef struct {
    logic              hit;
    logic              stored;
    logic [23:0]       move;
    logic signed [15:0] score;
    logic signed [15:0] eval;
    logic signed [7:0]  depth;
    logic [1:0]        bound;
  } tt_result_t;

  logic [63:0]        tbl_key   [TABLE_ENTRIES];
  logic [23:0]        tbl_move  [TABLE_ENTRIES];
  logic signed [15:0] tbl_score [TABLE_ENTRIES];
  logic signed [15:0] tbl_eval  [TABLE_ENTRIES];
  logic signed [7:0]  tbl_depth [TABLE_ENTRIES];
  logic [1:0]         tbl_bound [TABLE_ENTRIES];
  logic [GEN_W-1:0]   tbl_gen   [TABLE_ENTRIES];
  logic [GEN_W-1:0]   cur_gen;

  tt_result_t result_q[$];
  int errs = 0;

  function automatic int clamp_int(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Mate scores move by delta away from zero; everything else is left alone.
  function automatic int mate_adjust(int s, int delta);
    if (s > MATE_BOUND) return s + delta;
    if (s < -MATE_BOUND) return s - delta;
    return s;
  endfunction

  function automatic tt_result_t tt_access(logic kind, logic [IN_TDATA_W-1:0] d);
    logic [63:0]       key;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        bound;
    int                ply, sc, depth;
    logic              replace;
    tt_result_t        r;
    key   = d[63:0];
    slot  = key[SLOT_W-1:0];
    ply   = int'(d[138:131]);
    bound = d[130:129];
    depth = int'($signed(d[128:120]));
    r = '{default: 0};
    if (kind == KIND_PROBE) begin
      if (tbl_key[slot] == key) begin
        sc = int'(tbl_score[slot]);
        r.hit   = 1'b1;
        r.move  = tbl_move[slot];
        r.score = 16'(clamp_int(mate_adjust(sc, -ply), -32768, 32767));
        r.eval  = tbl_eval[slot];
        r.depth = tbl_depth[slot];
        r.bound = tbl_bound[slot];
      end
    end else begin
      // Depth is compared before clamping, as the stored depth never goes past 127.
      replace = (tbl_key[slot] != key) || (bound == BND_EXACT) ||
                (depth >= int'(tbl_depth[slot])) || (tbl_gen[slot] != cur_gen);
      if (replace) begin
        sc = int'($signed(d[103:88]));
        tbl_key[slot]   = key;
        tbl_move[slot]  = d[87:64];
        tbl_score[slot] = 16'(clamp_int(mate_adjust(sc, ply), -32768, 32767));
        tbl_eval[slot]  = 16'(clamp_int(int'($signed(d[119:104])), -INFINITE_VALUE,
                                        INFINITE_VALUE));
        tbl_depth[slot] = 8'(clamp_int(depth, -1, 127));
        tbl_bound[slot] = bound;
        tbl_gen[slot]   = cur_gen;
        r.stored = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      errs++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tt_result_t exp_r;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_key[i]   = '0;
        tbl_move[i]  = '0;
        tbl_score[i] = '0;
        tbl_eval[i]  = '0;
        tbl_depth[i] = '0;
        tbl_bound[i] = '0;
        tbl_gen[i]   = '0;
      end
      cur_gen = '0;
      result_q.delete();
    end else begin
      // A result leaving at this edge always belongs to an earlier input transaction.
      if (m_tvalid && m_tready) begin
        if (result_q.size() == 0) begin
          $error("result transaction with no expected result");
          errs++;
        end else begin
          exp_r = result_q.pop_front();
          check_field("hit", int'(exp_r.hit), int'(m_tuser[0]));
          check_field("stored", int'(exp_r.stored), int'(m_tuser[1]));
          check_field("move_out", int'(exp_r.move), int'(m_tdata[23:0]));
          check_field("score_out", int'(exp_r.score), int'($signed(m_tdata[39:24])));
          check_field("eval_out", int'(exp_r.eval), int'($signed(m_tdata[55:40])));
          check_field("depth_out", int'(exp_r.depth), int'($signed(m_tdata[63:56])));
          check_field("bound_out", int'(exp_r.bound), int'(m_tdata[65:64]));
        end
      end
      if (gen_we) cur_gen = gen_data;
      if (s_tvalid && s_tready) result_q.push_back(tt_access(s_tuser, s_tdata));
    end
    pending    <= result_q.size();
    fail_count <= errs;
  end

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import tte_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int PHASE_ITEMS  = 200;
  localparam logic [63:0] KEY_A = 64'h0123_4567_89AB_C5A5;
  localparam logic [63:0] KEY_B = 64'hFEDC_BA98_7654_35A5;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   gen_we;
  logic [GEN_W-1:0]       gen_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic [OUT_TUSER_W-1:0] m_tuser;
  int                     fail_count;
  int                     pending;

  int          cycle_count = 0;
  int          ready_mode = 0;
  int          ready_hold = 0;
  int          burst_left = 0;
  logic [63:0] key_pool[32];

  transposition_table_engine uut (
    .clk      (clk),
    .rst      (rst),
    .gen_we   (gen_we),
    .gen_data (gen_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  tte_checker chk (
    .clk        (clk),
    .rst        (rst),
    .gen_we     (gen_we),
    .gen_data   (gen_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // The result side picks one of four ready patterns at random and holds it for a random span.
  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= $urandom_range(0, 3);
      ready_hold <= $urandom_range(50, 400);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      2: m_tready <= ($urandom_range(0, 3) == 0);
      default: m_tready <= ((cycle_count % 7) < 3);
    endcase
  end

  function automatic logic [IN_TDATA_W-1:0] pack_item(logic [63:0] key, int move, int score,
                                                      int eval, int depth, logic [1:0] bound,
                                                      int ply);
    return {5'b0, ply[7:0], bound, depth[8:0], eval[15:0], score[15:0], move[23:0], key};
  endfunction

  // Scores lean toward the mate window edges and the saturation limits.
  function automatic int pick_score();
    case ($urandom_range(0, 5))
      0: return int'($urandom_range(0, 65534)) - 32767;
      1: return int'($urandom_range(31800, 32767));
      2: return -int'($urandom_range(31800, 32767));
      3: begin
        case ($urandom_range(0, 5))
          0: return 31872;
          1: return 31873;
          2: return -31872;
          3: return -31873;
          4: return 32767;
          default: return -32767;
        endcase
      end
      default: return int'($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    return key_pool[$urandom_range(0, 31)];
  endfunction

  function automatic logic [IN_TDATA_W-1:0] random_fields(logic [63:0] key);
    int depth;
    logic [1:0] bound;
    depth = ($urandom_range(0, 1) == 0) ? int'($urandom_range(0, 383)) - 128
                                        : int'($urandom_range(0, 20)) - 1;
    bound = ($urandom_range(0, 31) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    return pack_item(key, $urandom, pick_score(), pick_score(), depth, bound,
                     $urandom_range(0, 255));
  endfunction

  // Holds the transaction until it is taken, then ends the burst or keeps valid high.
  task automatic send_item(logic kind, logic [IN_TDATA_W-1:0] data);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= data;
    do @(posedge clk); while (!s_tready);
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(0, 40);
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain();
    if (s_tvalid) s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic set_generation(logic [GEN_W-1:0] value);
    drain();
    repeat (3) @(posedge clk);
    gen_we   <= 1'b1;
    gen_data <= value;
    @(posedge clk);
    gen_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [63:0] k;
    logic [GEN_W-1:0] gen_seq[8];
    int n;
    rst      <= 1'b1;
    gen_we   <= 1'b0;
    gen_data <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= KIND_PROBE;
    // Eight slots shared by 32 keys, so tags collide often; key zero is in the pool.
    for (int i = 0; i < 32; i++) begin
      key_pool[i] = {$urandom, $urandom};
      key_pool[i][11:0] = 12'(($urandom_range(0, 7) * 517) & 12'hFFF);
    end
    key_pool[0] = '0;
    gen_seq = '{8'd255, 8'd0, 8'($urandom), 8'd255, 8'd1, 8'($urandom), 8'd128, 8'd0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    set_generation(8'd0);

    // Empty entry with key zero hits; an unknown key misses.
    send_item(KIND_PROBE, pack_item(64'd0, 0, 0, 0, 0, BND_UPPER, 0));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_UPPER, 7));
    // Winning mate saturates, eval and depth clamp at the top.
    send_item(KIND_STORE, pack_item(KEY_A, 'hFFFFFF, 32767, 32767, 255, BND_EXACT, 255));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_UPPER, 0));
    // Same key, shallower, not exact, same generation: kept.
    send_item(KIND_STORE, pack_item(KEY_A, 'h123456, 5, 5, -128, BND_UPPER, 3));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_LOWER, 1));
    // Losing mate saturates, eval and depth clamp at the bottom.
    send_item(KIND_STORE, pack_item(KEY_A, 0, -32767, -32767, -128, BND_EXACT, 255));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_UPPER, 255));
    // Bound code three at equal depth replaces and reads back as three.
    send_item(KIND_STORE, pack_item(KEY_A, 'hABCDEF, 31873, 100, -1, 2'd3, 10));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_UPPER, 10));
    send_item(KIND_STORE, pack_item(KEY_A, 'h000001, 1, 1, 0, 2'd3, 10));
    // A different key in the same slot always replaces.
    send_item(KIND_STORE, pack_item(KEY_B, 'h0F0F0F, -31873, -32001, 0, BND_UPPER, 128));
    send_item(KIND_PROBE, pack_item(KEY_A, 0, 0, 0, 0, BND_UPPER, 0));
    send_item(KIND_PROBE, pack_item(KEY_B, 0, 0, 0, 0, BND_UPPER, 128));
    // Window edges: 31872 and -31872 both stay put.
    send_item(KIND_STORE, pack_item(64'd7, 'h7, 31872, 32001, 64, BND_LOWER, 100));
    send_item(KIND_PROBE, pack_item(64'd7, 0, 0, 0, 0, BND_UPPER, 100));
    send_item(KIND_STORE, pack_item(64'd0, 'h5, -31872, -32768 + 1, 3, BND_LOWER, 0));
    send_item(KIND_PROBE, pack_item(64'd0, 0, 0, 0, 0, BND_UPPER, 33));

    for (int ph = 0; ph < 8; ph++) begin
      set_generation(gen_seq[ph]);
      if (ph == 0) begin
        // New generation lets a shallow, inexact store through.
        send_item(KIND_STORE, pack_item(KEY_B, 'h33, 12, 12, -128, BND_LOWER, 0));
        send_item(KIND_PROBE, pack_item(KEY_B, 0, 0, 0, 0, BND_UPPER, 0));
      end
      n = 0;
      while (n < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) < 7) begin
          k = pick_key();
          send_item(KIND_STORE, random_fields(k));
          send_item(KIND_PROBE, random_fields(k));
          n += 2;
        end else begin
          send_item(logic'($urandom_range(0, 1)), random_fields(pick_key()));
          n += 1;
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/tte_pkg.sv
rtl/core/transposition_table_engine.sv
rtl/core/tte_checker.sv
bench/tte_checker.sv
bench/tb_top.sv
